@@ sv/pfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared codes, field widths and the result record of the packet FIFO.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int DATA_W = 8;
	localparam int REQ_W  = 2;
	localparam int OFF_W  = 9;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 2;

	localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_COMMIT  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DISCARD = 2'd2;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_PACKET    = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY_COMMIT = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW     = 2'd3;

	typedef struct packed {
		logic              byte_valid;
		logic              last_of_packet;
		logic [OFF_W-1:0]  bytes_delivered;
		logic [ST_W-1:0]   status;
		logic [CNT_W-1:0]  packets_stored;
	} pfc_result_t;

endpackage

@@ sv/pfc_byte_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_byte_ram
// Circular byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfc_byte_ram #(
	parameter int BYTE_DEPTH = 256,
	localparam int ADDR_W = $clog2(BYTE_DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [pfc_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [pfc_pkg::DATA_W-1:0] rdata
);
	import pfc_pkg::*;

	logic [DATA_W-1:0] mem [BYTE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/pfc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_core
// Packet bookkeeping: start ring, open packet, read offset and request decode.
// ----------------------------------------------------------------------------
module pfc_core #(
	parameter int BYTE_DEPTH = 256,
	parameter int PACKET_SLOTS = 4,
	localparam int ADDR_W = $clog2(BYTE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic [pfc_pkg::REQ_W-1:0]  req_type,
	input  logic [pfc_pkg::DATA_W-1:0] data_byte,
	input  logic [pfc_pkg::DATA_W-1:0] max_len,
	output pfc_pkg::pfc_result_t       result,
	output logic                       mem_we,
	output logic [ADDR_W-1:0]          mem_waddr,
	output logic [pfc_pkg::DATA_W-1:0] mem_wdata,
	output logic                       mem_re,
	output logic [ADDR_W-1:0]          mem_raddr
);
	import pfc_pkg::*;

	localparam int LEN_W = $clog2(BYTE_DEPTH + 1);
	localparam int SLOT_W = $clog2(PACKET_SLOTS);
	localparam int CMP_W = (LEN_W > OFF_W) ? LEN_W : OFF_W;

	logic [ADDR_W-1:0] starts_q [PACKET_SLOTS];
	logic [ADDR_W-1:0] open_start_q, head_start_q;
	logic [SLOT_W-1:0] wr_slot_q, rd_slot_q;
	logic [LEN_W-1:0]  open_len_q;
	logic [OFF_W-1:0]  rd_off_q;

	logic [ADDR_W-1:0] open_start_d, head_start_d, head_end, wr_pos;
	logic [SLOT_W-1:0] wr_slot_d, rd_slot_d;
	logic [LEN_W-1:0]  open_len_d, stored_len, space, head_size;
	logic [OFF_W-1:0]  rd_off_d, off_inc;
	logic [CMP_W-1:0]  limit;
	logic [SLOT_W:0]   pkt_cnt;
	logic              nonempty, commit;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(PACKET_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
			input logic [CMP_W-1:0] b);
		logic [CMP_W:0] sum;
		sum = (CMP_W+1)'(a) + (CMP_W+1)'(b);
		if (sum >= (CMP_W+1)'(BYTE_DEPTH)) begin
			sum = sum - (CMP_W+1)'(BYTE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	// distance between two positions, equal positions meaning a whole store
	function automatic logic [LEN_W-1:0] pkt_len(input logic [ADDR_W-1:0] from,
			input logic [ADDR_W-1:0] to);
		logic [LEN_W-1:0] d;
		if (to > from) begin
			d = LEN_W'(to) - LEN_W'(from);
		end else begin
			d = LEN_W'(to) + LEN_W'(BYTE_DEPTH) - LEN_W'(from);
		end
		return d;
	endfunction

	always_comb begin
		nonempty = (rd_slot_q != wr_slot_q);
		stored_len = nonempty ? pkt_len(head_start_q, open_start_q) : '0;
		space = LEN_W'(BYTE_DEPTH) - stored_len;
		head_end = starts_q[slot_next(rd_slot_q)];
		head_size = pkt_len(head_start_q, head_end);
		limit = (CMP_W'(head_size) < CMP_W'(max_len)) ? CMP_W'(head_size) : CMP_W'(max_len);
		wr_pos = wrap_add(open_start_q, CMP_W'(open_len_q));
		off_inc = rd_off_q + 1'b1;

		open_start_d = open_start_q;
		head_start_d = head_start_q;
		wr_slot_d = wr_slot_q;
		rd_slot_d = rd_slot_q;
		open_len_d = open_len_q;
		rd_off_d = rd_off_q;
		commit = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = wr_pos;
		mem_wdata = data_byte;
		mem_raddr = wrap_add(head_start_q, CMP_W'(rd_off_q));
		result = '0;

		unique case (req_type)
			REQ_WRITE: begin
				if (open_len_q >= space) begin
					result.status = ST_OVERFLOW;
				end else begin
					mem_we = item_valid;
					open_len_d = open_len_q + 1'b1;
				end
			end
			REQ_COMMIT: begin
				if (open_len_q == '0) begin
					result.status = ST_EMPTY_COMMIT;
				end else if (slot_next(wr_slot_q) == rd_slot_q) begin
					result.status = ST_OVERFLOW;
				end else begin
					commit = 1'b1;
					wr_slot_d = slot_next(wr_slot_q);
					open_start_d = wr_pos;
					open_len_d = '0;
				end
			end
			REQ_DISCARD: begin
				open_len_d = '0;
			end
			REQ_READ: begin
				if (!nonempty) begin
					result.status = ST_NO_PACKET;
				end else begin
					result.bytes_delivered = rd_off_q;
					if (CMP_W'(rd_off_q) < limit) begin
						mem_re = item_valid;
						result.byte_valid = 1'b1;
						result.bytes_delivered = off_inc;
						rd_off_d = off_inc;
					end
					if (CMP_W'(rd_off_d) >= limit) begin
						result.last_of_packet = 1'b1;
						rd_slot_d = slot_next(rd_slot_q);
						head_start_d = head_end;
						rd_off_d = '0;
					end
				end
			end
			default: begin
				result.status = ST_OK;
			end
		endcase

		if (wr_slot_d >= rd_slot_d) begin
			pkt_cnt = (SLOT_W+1)'(wr_slot_d) - (SLOT_W+1)'(rd_slot_d);
		end else begin
			pkt_cnt = (SLOT_W+1)'(wr_slot_d) + (SLOT_W+1)'(PACKET_SLOTS)
				- (SLOT_W+1)'(rd_slot_d);
		end
		result.packets_stored = pkt_cnt[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PACKET_SLOTS; i++) begin
				starts_q[i] <= '0;
			end
			open_start_q <= '0;
			head_start_q <= '0;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			open_len_q <= '0;
			rd_off_q <= '0;
		end else if (item_valid) begin
			if (commit) begin
				starts_q[wr_slot_d] <= wr_pos;
			end
			open_start_q <= open_start_d;
			head_start_q <= head_start_d;
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			open_len_q <= open_len_d;
			rd_off_q <= rd_off_d;
		end
	end

endmodule

@@ sv/packet_fifo_with_commit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_fifo_with_commit
// Packet FIFO over a circular byte store with commit, discard and capped read.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, data_byte, max_len) is taken at a rising edge with
//   start high and busy low. busy stays low, so one request per cycle.
//   Write appends a byte to the open packet, commit closes it, discard drops
//   it, read gives one byte of the oldest stored packet, cut at max_len.
//   Every request gives one item on the result ports, marked by done for one
//   cycle, after the input register and then the result register with the
//   byte store read port. Throughput is one item per cycle; the request
//   logic and the store ports set that figure.
//   The receiver cannot hold results off; done is a pure strobe.
//   Reset empties the ring and the open packet and drops in-flight requests.
//   The byte store is not cleared; only written bytes are ever read.
// ----------------------------------------------------------------------------
module packet_fifo_with_commit #(
	parameter int BYTE_DEPTH = 256,
	parameter int PACKET_SLOTS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [pfc_pkg::REQ_W-1:0]  req_type,
	input  logic [pfc_pkg::DATA_W-1:0] data_byte,
	input  logic [pfc_pkg::DATA_W-1:0] max_len,
	output logic                       done,
	output logic [pfc_pkg::DATA_W-1:0] read_byte,
	output logic                       byte_valid,
	output logic                       last_of_packet,
	output logic [pfc_pkg::OFF_W-1:0]  bytes_delivered,
	output logic [pfc_pkg::ST_W-1:0]   status,
	output logic [pfc_pkg::CNT_W-1:0]  packets_stored
);
	import pfc_pkg::*;

	localparam int ADDR_W = $clog2(BYTE_DEPTH);

	logic              item_s1, item_s2;
	logic [REQ_W-1:0]  req_type_s1;
	logic [DATA_W-1:0] data_byte_s1, max_len_s1;
	pfc_result_t       result, result_s2;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= 1'b0;
			item_s2 <= 1'b0;
		end else begin
			item_s1 <= start && !busy;
			item_s2 <= item_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_type_s1 <= req_type;
			data_byte_s1 <= data_byte;
			max_len_s1 <= max_len;
		end
		if (item_s1) begin
			result_s2 <= result;
		end
	end

	pfc_core #(
		.BYTE_DEPTH(BYTE_DEPTH),
		.PACKET_SLOTS(PACKET_SLOTS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_s1),
		.req_type(req_type_s1),
		.data_byte(data_byte_s1),
		.max_len(max_len_s1),
		.result(result),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr)
	);

	pfc_byte_ram #(
		.BYTE_DEPTH(BYTE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign done = item_s2;
	assign read_byte = result_s2.byte_valid ? mem_rdata : '0;
	assign byte_valid = result_s2.byte_valid;
	assign last_of_packet = result_s2.last_of_packet;
	assign bytes_delivered = result_s2.bytes_delivered;
	assign status = result_s2.status;
	assign packets_stored = result_s2.packets_stored;

endmodule

@@ sv/pfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the packet FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [pfc_pkg::DATA_W-1:0] read_byte,
	input logic                       byte_valid,
	input logic                       last_of_packet,
	input logic [pfc_pkg::OFF_W-1:0]  bytes_delivered,
	input logic [pfc_pkg::ST_W-1:0]   status,
	input logic [pfc_pkg::CNT_W-1:0]  packets_stored
);
	import pfc_pkg::*;

	// each accepted item is followed by a result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing after accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !byte_valid) |-> (read_byte == '0))
		else $error("read_byte not zero without a byte");

	a_ok_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (byte_valid || last_of_packet)) |-> (status == ST_OK))
		else $error("read result with error status");

	a_no_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NO_PACKET) |->
			(packets_stored == '0 && bytes_delivered == '0 && !byte_valid))
		else $error("no-packet result carries data");

endmodule

bind packet_fifo_with_commit pfc_checker u_pfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.read_byte(read_byte),
	.byte_valid(byte_valid),
	.last_of_packet(last_of_packet),
	.bytes_delivered(bytes_delivered),
	.status(status),
	.packets_stored(packets_stored)
);

@@ tb/packet_fifo_with_commit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_fifo_with_commit_test
// Self-checking bench for the packet FIFO with commit and discard. Requests
// are driven with random gaps. A local model of the byte store, the ring of
// packet starts and the open packet predicts every result item, and the
// checker compares each strobed item field by field in order. Directed
// tests cover the corner cases: empty read, empty commit, truncation, a
// lowered or zero length cap, a full slot ring and a full byte store. They
// are followed by random packet traffic mixed with noise.
// ----------------------------------------------------------------------------
module packet_fifo_with_commit_test;

	import pfc_pkg::*;

	localparam int STORE_BYTES = 256;
	localparam int RANDOM_ITEMS = 900;
	localparam int MAX_GAP = 9;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [DATA_W-1:0] rbyte;
		pfc_result_t       flags;
	} fifo_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [REQ_W-1:0]  req_type = REQ_WRITE;
	logic [DATA_W-1:0] data_byte = '0;
	logic [DATA_W-1:0] max_len = '0;
	logic              done;
	logic [DATA_W-1:0] read_byte;
	logic              byte_valid;
	logic              last_of_packet;
	logic [OFF_W-1:0]  bytes_delivered;
	logic [ST_W-1:0]   status;
	logic [CNT_W-1:0]  packets_stored;

	// model of the fifo contents
	logic [DATA_W-1:0] byte_mem [STORE_BYTES];
	logic [DATA_W-1:0] slot_pos [4];
	logic [1:0]        wr_slot;
	logic [1:0]        rd_slot;
	int                open_len;
	int                rd_off;

	fifo_result_t pending_results [$];

	int  items_sent = 0;
	int  err_count = 0;
	int  cycle_count = 0;
	int  bytes_read = 0;
	int  pkts_released = 0;
	int  refused = 0;
	int  empty_reads = 0;
	int  empty_commits = 0;
	bit  no_idle = 1'b0;

	packet_fifo_with_commit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.max_len        (max_len),
		.done           (done),
		.read_byte      (read_byte),
		.byte_valid     (byte_valid),
		.last_of_packet (last_of_packet),
		.bytes_delivered(bytes_delivered),
		.status         (status),
		.packets_stored (packets_stored)
	);

	always #5 clk = ~clk;

	function automatic fifo_result_t fifo_request(logic [REQ_W-1:0] req,
			logic [DATA_W-1:0] dbyte, logic [DATA_W-1:0] cap);
		fifo_result_t r;
		logic [DATA_W-1:0] pos;
		logic [DATA_W-1:0] span;
		int held;
		int size;
		int limit;
		r = '0;
		case (req)
			REQ_WRITE: begin
				span = slot_pos[wr_slot] - slot_pos[rd_slot];
				if (rd_slot == wr_slot)
					held = 0;
				else
					held = (span == 0) ? STORE_BYTES : int'(span);
				if (open_len >= STORE_BYTES - held) begin
					r.flags.status = ST_OVERFLOW;
				end else begin
					pos = slot_pos[wr_slot] + open_len[7:0];
					byte_mem[pos] = dbyte;
					open_len++;
				end
			end
			REQ_COMMIT: begin
				if (open_len == 0) begin
					r.flags.status = ST_EMPTY_COMMIT;
				end else if (wr_slot + 2'd1 == rd_slot) begin
					r.flags.status = ST_OVERFLOW;
				end else begin
					pos = slot_pos[wr_slot] + open_len[7:0];
					wr_slot = wr_slot + 2'd1;
					slot_pos[wr_slot] = pos;
					open_len = 0;
				end
			end
			REQ_DISCARD: begin
				open_len = 0;
			end
			default: begin
				if (rd_slot == wr_slot) begin
					r.flags.status = ST_NO_PACKET;
				end else begin
					span = slot_pos[rd_slot + 2'd1] - slot_pos[rd_slot];
					size = (span == 0) ? STORE_BYTES : int'(span);
					limit = (size < int'(cap)) ? size : int'(cap);
					if (rd_off < limit) begin
						pos = slot_pos[rd_slot] + rd_off[7:0];
						r.rbyte = byte_mem[pos];
						r.flags.byte_valid = 1'b1;
						rd_off++;
					end
					r.flags.bytes_delivered = rd_off[OFF_W-1:0];
					if (rd_off >= limit) begin
						r.flags.last_of_packet = 1'b1;
						rd_slot = rd_slot + 2'd1;
						rd_off = 0;
					end
				end
			end
		endcase
		r.flags.packets_stored = wr_slot - rd_slot;
		return r;
	endfunction

	// result checker and predictor, both on the rising edge
	always @(posedge clk) begin
		fifo_result_t got;
		fifo_result_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				got = {read_byte, byte_valid, last_of_packet, bytes_delivered, status,
					packets_stored};
				if (pending_results.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT) begin
						$write("%0t: unexpected item byte=%h valid=%b last=%b",
							$realtime, got.rbyte, got.flags.byte_valid,
							got.flags.last_of_packet);
						$display(" dlv=%0d st=%0d n=%0d", got.flags.bytes_delivered,
							got.flags.status, got.flags.packets_stored);
					end
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= REPORT_LIMIT) begin
							$display("%0t: expected byte=%h v=%b l=%b dlv=%0d st=%0d n=%0d",
								$realtime, want.rbyte, want.flags.byte_valid,
								want.flags.last_of_packet, want.flags.bytes_delivered,
								want.flags.status, want.flags.packets_stored);
							$display("%0t:      got byte=%h v=%b l=%b dlv=%0d st=%0d n=%0d",
								$realtime, got.rbyte, got.flags.byte_valid,
								got.flags.last_of_packet, got.flags.bytes_delivered,
								got.flags.status, got.flags.packets_stored);
						end
					end
				end
			end
			if (start && !busy) begin
				want = fifo_request(req_type, data_byte, max_len);
				pending_results.push_back(want);
				if (want.flags.byte_valid)
					bytes_read++;
				if (want.flags.last_of_packet)
					pkts_released++;
				case (want.flags.status)
					ST_OVERFLOW:     refused++;
					ST_NO_PACKET:    empty_reads++;
					ST_EMPTY_COMMIT: empty_commits++;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(logic [REQ_W-1:0] req, logic [DATA_W-1:0] dbyte,
			logic [DATA_W-1:0] cap);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		data_byte <= dbyte;
		max_len <= cap;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic test_basic_requests();
		send_item(REQ_READ, 8'h00, 8'hFF);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_DISCARD, 8'hFF, 8'hFF);
		send_item(REQ_WRITE, 8'h00, 8'h00);
		send_item(REQ_WRITE, 8'hFF, 8'hFF);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_READ, 8'h00, 8'hFF);
		send_item(REQ_READ, 8'h00, 8'hFF);
		// zero cap releases with no byte
		send_item(REQ_WRITE, 8'hA5, 8'h00);
		send_item(REQ_WRITE, 8'h5A, 8'h00);
		send_item(REQ_WRITE, 8'h3C, 8'h00);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_READ, 8'h00, 8'h00);
		// discard restarts the open packet
		send_item(REQ_WRITE, 8'h11, 8'h00);
		send_item(REQ_WRITE, 8'h22, 8'h00);
		send_item(REQ_DISCARD, 8'h00, 8'h00);
		send_item(REQ_WRITE, 8'h33, 8'h00);
		send_item(REQ_WRITE, 8'h44, 8'h00);
		send_item(REQ_WRITE, 8'h55, 8'h00);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		// cap lowered to the bytes already read
		send_item(REQ_READ, 8'h00, 8'h03);
		send_item(REQ_READ, 8'h00, 8'h01);
		// truncated packet
		send_item(REQ_WRITE, 8'h66, 8'h00);
		send_item(REQ_WRITE, 8'h77, 8'h00);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_READ, 8'h00, 8'h01);
	endtask

	task automatic test_slot_ring_full();
		for (int i = 1; i <= 3; i++) begin
			send_item(REQ_WRITE, 8'(i), 8'h00);
			send_item(REQ_COMMIT, 8'h00, 8'h00);
		end
		send_item(REQ_WRITE, 8'h04, 8'h00);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_READ, 8'h00, 8'hFF);
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		for (int i = 0; i < 4; i++)
			send_item(REQ_READ, 8'h00, 8'hFF);
	endtask

	task automatic test_store_full();
		for (int i = 0; i <= STORE_BYTES; i++)
			send_item(REQ_WRITE, 8'($urandom), 8'($urandom));
		send_item(REQ_COMMIT, 8'h00, 8'h00);
		send_item(REQ_WRITE, 8'h99, 8'h00);
		send_item(REQ_READ, 8'h00, 8'h02);
		send_item(REQ_READ, 8'h00, 8'h02);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int pick;
		int len;
		int cap_mode;
		logic [DATA_W-1:0] cap;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 39) == 0)
						send_item(REQ_DISCARD, 8'($urandom), 8'($urandom));
					send_item(REQ_WRITE, 8'($urandom), 8'($urandom));
				end
				if ($urandom_range(0, 9) == 0)
					send_item(REQ_DISCARD, 8'($urandom), 8'($urandom));
				else
					send_item(REQ_COMMIT, 8'($urandom), 8'($urandom));
			end else if (pick < 85) begin
				len = $urandom_range(1, 24);
				cap_mode = $urandom_range(0, 9);
				for (int i = 0; i < len; i++) begin
					if (cap_mode < 6)
						cap = 8'hFF;
					else if (cap_mode < 9)
						cap = 8'($urandom_range(1, 15));
					else
						cap = 8'($urandom);
					send_item(REQ_READ, 8'($urandom), cap);
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_item(REQ_W'($urandom), 8'($urandom), 8'($urandom));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			slot_pos[i] = '0;
		wr_slot = '0;
		rd_slot = '0;
		open_len = 0;
		rd_off = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_requests();
		test_slot_ring_full();
		test_store_full();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d bytes read, %0d packets released, %0d refused",
			items_sent, bytes_read, pkts_released, refused);
		$display("%0d reads with no packet, %0d empty commits, %0d mismatches",
			empty_reads, empty_commits, err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
